### hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, codes and saturation helper for the Chebyshev series evaluator.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SPAN_W      = 34;
  localparam int unsigned SAT_W       = 68;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned SCALE_W     = 31;
  localparam int unsigned ORDER_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd31;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_VALUE = 2'd1,
    OP_DERIV = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_LOW  = 2'd0,
    REG_INTERVAL_HIGH = 2'd1,
    REG_UNIT_SCALE    = 2'd2,
    REG_SERIES_ORDER  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_NONE,
    KIND_VALUE,
    KIND_DERIV,
    KIND_BAD
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DONE,
    ST_V_MAP,
    ST_V_INIT,
    ST_V_MUL,
    ST_V_ADD,
    ST_V_FMUL,
    ST_V_FIN,
    ST_D_MAP,
    ST_D_INIT,
    ST_D_S0,
    ST_D_S1,
    ST_D_K1,
    ST_D_K2,
    ST_D_K3,
    ST_D_K4,
    ST_D_K5,
    ST_D_ACC,
    ST_D_OUT,
    ST_D_FIN
  } back_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] interval_low;
    logic signed [DATA_W-1:0] interval_high;
    logic [SCALE_W-1:0]       unit_scale;
    logic [ORDER_W-1:0]       series_order;
  } cfg_t;

  typedef struct packed {
    kind_e                    kind;
    logic [IDX_W-1:0]         idx;
    logic signed [SPAN_W-1:0] data;
  } entry_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-DATA_W:0]    upper;
    logic signed [DATA_W-1:0] r;
    upper = v[SAT_W-1:DATA_W-1];
    if (&upper || ~|upper) begin
      r = v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Classifies incoming words and forms the centered argument span 2x-low-high.
// ----------------------------------------------------------------------------
module cse_front #(
  parameter int unsigned MAX_ORDER = 31
) (
  input  logic [cse_pkg::OP_W-1:0]           operation_i,
  input  logic [cse_pkg::IDX_W-1:0]          coefficient_index_i,
  input  logic signed [cse_pkg::DATA_W-1:0]  coefficient_value_i,
  input  logic signed [cse_pkg::DATA_W-1:0]  argument_i,
  input  cse_pkg::cfg_t                      cfg_i,
  output cse_pkg::entry_t                    entry_o
);

  localparam int unsigned SPW = cse_pkg::SPAN_W;

  logic                  out_of_range;
  logic signed [SPW-1:0] span;
  logic                  idx_ok;

  assign out_of_range = (argument_i < cfg_i.interval_low) || (argument_i > cfg_i.interval_high);
  assign span = (SPW'(argument_i) <<< 1) - SPW'(cfg_i.interval_low)
              - SPW'(cfg_i.interval_high);
  assign idx_ok = (32'(coefficient_index_i) <= MAX_ORDER);

  always_comb begin
    entry_o.idx  = coefficient_index_i;
    entry_o.data = span;
    unique case (cse_pkg::op_e'(operation_i))
      cse_pkg::OP_WRITE: begin
        entry_o.kind = idx_ok ? cse_pkg::KIND_WRITE : cse_pkg::KIND_NONE;
        entry_o.data = SPW'(coefficient_value_i);
      end
      cse_pkg::OP_VALUE: begin
        entry_o.kind = out_of_range ? cse_pkg::KIND_BAD : cse_pkg::KIND_VALUE;
      end
      cse_pkg::OP_DERIV: begin
        entry_o.kind = out_of_range ? cse_pkg::KIND_BAD : cse_pkg::KIND_DERIV;
      end
      cse_pkg::OP_NONE: begin
        entry_o.kind = cse_pkg::KIND_NONE;
      end
      default: begin
        entry_o.kind = cse_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

### hw/rtl/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Two-entry queue between the classifying front end and the evaluation core.
// ----------------------------------------------------------------------------
module cse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cse_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output cse_pkg::entry_t entry_o,
  output logic            empty_o
);

  localparam int unsigned DEPTH = cse_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  cse_pkg::entry_t slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### hw/rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Evaluation core: coefficient memory, shared multiplier and the sequencer for
// the Clenshaw value recurrence and the derivative recurrence.
// ----------------------------------------------------------------------------
module cse_back #(
  parameter int unsigned MAX_ORDER = 31,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cse_pkg::cfg_t                     cfg_i,
  input  logic                              q_empty_i,
  input  cse_pkg::entry_t                   q_entry_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [cse_pkg::DATA_W-1:0] result_value_o,
  output logic                              bad_argument_o
);

  localparam int unsigned DW    = cse_pkg::DATA_W;
  localparam int unsigned SPW   = cse_pkg::SPAN_W;
  localparam int unsigned SW    = cse_pkg::SAT_W;
  localparam int unsigned DEPTH = MAX_ORDER + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);

  cse_pkg::back_state_e state_q, state_d;

  logic signed [DW-1:0]  coef_mem [DEPTH];
  logic signed [DW-1:0]  coef_q;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;

  logic signed [DW-1:0]  recip [DEPTH];

  logic signed [SPW-1:0] d_q, d_d;
  logic signed [DW-1:0]  t_q, t_d, p_q, p_d, q_q, q_d, s_q, s_d;
  logic signed [DW-1:0]  a_q, a_d, r2_q, r2_d, res_q, res_d;
  logic signed [DW-1:0]  prod_q, prod_d;
  logic                  res_bad_q, res_bad_d;
  logic                  acc_q, acc_d;
  logic [AW-1:0]         k_q, k_d;
  logic [AW-1:0]         m_c;

  logic signed [DW-1:0]  out_value_q;
  logic                  out_bad_q, out_valid_q, out_load, out_free;

  logic signed [SPW-1:0]     mul_a;
  logic signed [DW-1:0]      mul_b;
  logic                      mul_wide, mul_en;
  logic signed [SPW+DW-1:0]  mul_full, mul_shr;

  logic signed [DW-1:0]  v_step, v_fin, quad_t, dbl_t, s_first, s_acc, diff_c, r_c;
  logic signed [AW+DW:0] kr_wide;

  // reciprocal table round(2^frac / j)
  assign recip[0] = '0;
  for (genvar j = 1; j < DEPTH; j++) begin : g_recip
    localparam longint unsigned RV = ((64'd1 << FRAC_BITS) + j / 2) / j;
    assign recip[j] = DW'(RV);
  end

  // order clamped to the supported range
  always_comb begin
    if (cfg_i.series_order < cse_pkg::ORDER_W'(2)) begin
      m_c = AW'(2);
    end else if (32'(cfg_i.series_order) > MAX_ORDER) begin
      m_c = AW'(MAX_ORDER);
    end else begin
      m_c = AW'(cfg_i.series_order);
    end
  end

  // shared multiplier with floor shift and saturation
  assign mul_full = mul_a * mul_b;
  assign mul_shr  = mul_wide ? (mul_full >>> (FRAC_BITS + 1)) : (mul_full >>> FRAC_BITS);
  assign prod_d   = cse_pkg::sat32(SW'(mul_shr));

  assign v_step  = cse_pkg::sat32((SW'(prod_q) <<< 1) + SW'(coef_q) - SW'(p_q));
  assign v_fin   = cse_pkg::sat32(SW'(prod_q) - SW'(p_q) + SW'(coef_q >>> 1));
  assign quad_t  = cse_pkg::sat32(SW'(prod_q) <<< 2);
  assign dbl_t   = cse_pkg::sat32(SW'(prod_q) <<< 1);
  assign s_first = cse_pkg::sat32(SW'(coef_q) + SW'(prod_q));
  assign s_acc   = cse_pkg::sat32(SW'(s_q) + SW'(prod_q));
  assign diff_c  = cse_pkg::sat32(SW'(prod_q) - SW'(r2_q));
  assign kr_wide = $signed({1'b0, k_q}) * diff_c;
  assign r_c     = cse_pkg::sat32(SW'(kr_wide));

  assign out_free       = !out_valid_q || pop_i;
  assign empty_o        = !out_valid_q;
  assign result_value_o = out_value_q;
  assign bad_argument_o = out_bad_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cse_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.kind == cse_pkg::KIND_VALUE) begin
            state_d = cse_pkg::ST_V_MAP;
          end else if (q_entry_i.kind == cse_pkg::KIND_DERIV) begin
            state_d = cse_pkg::ST_D_MAP;
          end else begin
            state_d = cse_pkg::ST_DONE;
          end
        end
      end
      cse_pkg::ST_DONE:   if (out_free) state_d = cse_pkg::ST_IDLE;
      cse_pkg::ST_V_MAP:  state_d = cse_pkg::ST_V_INIT;
      cse_pkg::ST_V_INIT: state_d = cse_pkg::ST_V_MUL;
      cse_pkg::ST_V_MUL:  state_d = cse_pkg::ST_V_ADD;
      cse_pkg::ST_V_ADD: begin
        state_d = (k_q == AW'(1)) ? cse_pkg::ST_V_FMUL : cse_pkg::ST_V_MUL;
      end
      cse_pkg::ST_V_FMUL: state_d = cse_pkg::ST_V_FIN;
      cse_pkg::ST_V_FIN:  state_d = cse_pkg::ST_DONE;
      cse_pkg::ST_D_MAP:  state_d = cse_pkg::ST_D_INIT;
      cse_pkg::ST_D_INIT: state_d = cse_pkg::ST_D_S0;
      cse_pkg::ST_D_S0:   state_d = cse_pkg::ST_D_S1;
      cse_pkg::ST_D_S1: begin
        state_d = (m_c == AW'(2)) ? cse_pkg::ST_D_OUT : cse_pkg::ST_D_K1;
      end
      cse_pkg::ST_D_K1:   state_d = cse_pkg::ST_D_K2;
      cse_pkg::ST_D_K2:   state_d = cse_pkg::ST_D_K3;
      cse_pkg::ST_D_K3:   state_d = cse_pkg::ST_D_K4;
      cse_pkg::ST_D_K4:   state_d = cse_pkg::ST_D_K5;
      cse_pkg::ST_D_K5: begin
        state_d = (k_q == m_c) ? cse_pkg::ST_D_ACC : cse_pkg::ST_D_K1;
      end
      cse_pkg::ST_D_ACC:  state_d = cse_pkg::ST_D_OUT;
      cse_pkg::ST_D_OUT:  state_d = cse_pkg::ST_D_FIN;
      cse_pkg::ST_D_FIN:  state_d = cse_pkg::ST_DONE;
      default:            state_d = cse_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    d_d       = d_q;
    t_d       = t_q;
    p_d       = p_q;
    q_d       = q_q;
    s_d       = s_q;
    a_d       = a_q;
    r2_d      = r2_q;
    k_d       = k_q;
    acc_d     = acc_q;
    res_d     = res_q;
    res_bad_d = res_bad_q;
    mul_a     = '0;
    mul_b     = '0;
    mul_wide  = 1'b0;
    mul_en    = 1'b0;
    rd_addr   = k_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      cse_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          d_d       = q_entry_i.data;
          res_d     = '0;
          res_bad_d = (q_entry_i.kind == cse_pkg::KIND_BAD);
          mem_we    = (q_entry_i.kind == cse_pkg::KIND_WRITE);
        end
      end
      cse_pkg::ST_DONE: begin
        out_load = out_free;
      end
      cse_pkg::ST_V_MAP: begin
        mul_a    = d_q;
        mul_b    = $signed({1'b0, cfg_i.unit_scale});
        mul_wide = 1'b1;
        mul_en   = 1'b1;
        rd_addr  = m_c;
      end
      cse_pkg::ST_V_INIT: begin
        t_d = prod_q;
        q_d = coef_q;
        p_d = '0;
        k_d = m_c - AW'(1);
      end
      cse_pkg::ST_V_MUL: begin
        mul_a  = SPW'(t_q);
        mul_b  = q_q;
        mul_en = 1'b1;
      end
      cse_pkg::ST_V_ADD: begin
        p_d = q_q;
        q_d = v_step;
        k_d = k_q - AW'(1);
      end
      cse_pkg::ST_V_FMUL: begin
        mul_a   = SPW'(t_q);
        mul_b   = q_q;
        mul_en  = 1'b1;
        rd_addr = '0;
      end
      cse_pkg::ST_V_FIN: begin
        res_d = v_fin;
      end
      cse_pkg::ST_D_MAP: begin
        mul_a    = d_q;
        mul_b    = $signed({1'b0, cfg_i.unit_scale});
        mul_wide = 1'b1;
        mul_en   = 1'b1;
        rd_addr  = AW'(2);
      end
      cse_pkg::ST_D_INIT: begin
        t_d     = prod_q;
        q_d     = quad_t;
        p_d     = ONE_Q;
        rd_addr = AW'(2);
      end
      cse_pkg::ST_D_S0: begin
        mul_a   = SPW'(q_q);
        mul_b   = coef_q;
        mul_en  = 1'b1;
        rd_addr = AW'(1);
      end
      cse_pkg::ST_D_S1: begin
        s_d   = s_first;
        k_d   = AW'(3);
        acc_d = 1'b0;
      end
      cse_pkg::ST_D_K1: begin
        if (acc_q) begin
          s_d = s_acc;
        end
        acc_d  = 1'b0;
        mul_a  = SPW'(t_q);
        mul_b  = q_q;
        mul_en = 1'b1;
      end
      cse_pkg::ST_D_K2: begin
        a_d    = dbl_t;
        mul_a  = SPW'(p_q);
        mul_b  = recip[k_q - AW'(2)];
        mul_en = 1'b1;
      end
      cse_pkg::ST_D_K3: begin
        r2_d   = prod_q;
        mul_a  = SPW'(a_q);
        mul_b  = recip[k_q - AW'(1)];
        mul_en = 1'b1;
      end
      cse_pkg::ST_D_K4: begin
        p_d     = q_q;
        q_d     = r_c;
        rd_addr = k_q;
      end
      cse_pkg::ST_D_K5: begin
        mul_a  = SPW'(coef_q);
        mul_b  = q_q;
        mul_en = 1'b1;
        if (k_q != m_c) begin
          k_d   = k_q + AW'(1);
          acc_d = 1'b1;
        end
      end
      cse_pkg::ST_D_ACC: begin
        s_d = s_acc;
      end
      cse_pkg::ST_D_OUT: begin
        mul_a  = SPW'(s_q);
        mul_b  = $signed({1'b0, cfg_i.unit_scale});
        mul_en = 1'b1;
      end
      cse_pkg::ST_D_FIN: begin
        res_d = prod_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cse_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    t_q       <= t_d;
    p_q       <= p_d;
    q_q       <= q_d;
    s_q       <= s_d;
    a_q       <= a_d;
    r2_q      <= r2_d;
    k_q       <= k_d;
    res_q     <= res_d;
    res_bad_q <= res_bad_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      out_value_q <= res_q;
      out_bad_q   <= res_bad_q;
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[AW'(q_entry_i.idx)] <= q_entry_i.data[DW-1:0];
    end
    coef_q <= coef_mem[rd_addr];
  end

endmodule

### hw/rtl/chebyshev_series_evaluator.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Chebyshev series value and derivative over a configurable interval.
// ----------------------------------------------------------------------------
// from a pop of the internal queue: write, unused code and bad argument go to
//   done; value runs map, init, a multiply/add loop, final multiply, finish;
//   derivative runs map, init, two seeds, a coefficient loop, sum, scale, finish
// the core pops a new entry only from idle, after its last result is loaded
// asynchronous active-low reset clears control and queue registers and loads the
//   config defaults; coefficient memory stays undefined until written
module chebyshev_series_evaluator #(
  parameter int unsigned MAX_ORDER = 31,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [cse_pkg::OP_W-1:0]             operation_i,
  input  logic [cse_pkg::IDX_W-1:0]            coefficient_index_i,
  input  logic signed [cse_pkg::DATA_W-1:0]    coefficient_value_i,
  input  logic signed [cse_pkg::DATA_W-1:0]    argument_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [cse_pkg::DATA_W-1:0]    result_value_o,
  output logic                                 bad_argument_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cse_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cse_pkg::DATA_W-1:0]           cfg_data_i
);

  localparam int unsigned DW = cse_pkg::DATA_W;
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);

  cse_pkg::cfg_t   cfg_q;
  cse_pkg::entry_t front_entry, back_entry;
  logic            q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_low  <= -ONE_Q;
      cfg_q.interval_high <= ONE_Q;
      cfg_q.unit_scale    <= cse_pkg::SCALE_W'(ONE_Q);
      cfg_q.series_order  <= cse_pkg::ORDER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cse_pkg::cfg_reg_e'(cfg_index_i))
        cse_pkg::REG_INTERVAL_LOW:  cfg_q.interval_low  <= cfg_data_i;
        cse_pkg::REG_INTERVAL_HIGH: cfg_q.interval_high <= cfg_data_i;
        cse_pkg::REG_UNIT_SCALE:    cfg_q.unit_scale    <= cfg_data_i[cse_pkg::SCALE_W-1:0];
        cse_pkg::REG_SERIES_ORDER:  cfg_q.series_order  <= cfg_data_i[cse_pkg::ORDER_W-1:0];
        default:                    cfg_q               <= cfg_q;
      endcase
    end
  end

  cse_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .operation_i         (operation_i),
    .coefficient_index_i (coefficient_index_i),
    .coefficient_value_i (coefficient_value_i),
    .argument_i          (argument_i),
    .cfg_i               (cfg_q),
    .entry_o             (front_entry)
  );

  cse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .entry_o (back_entry),
    .empty_o (q_empty)
  );

  cse_back #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_entry_i      (back_entry),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .result_value_o (result_value_o),
    .bad_argument_o (bad_argument_o)
  );

endmodule

### hw/rtl/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks on the Chebyshev series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cse_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [cse_pkg::DATA_W-1:0] result_value_o,
  input logic                              bad_argument_o,
  input logic                              cfg_ready_o
);

  // nothing waits on either side while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result side not empty during reset");

  a_reset_not_full: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("input side full right after reset");

  // a bad argument always comes with a zero value
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_argument_o) |-> (result_value_o == '0))
    else $error("bad argument with nonzero value");

  // waiting word holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_value_o) && $stable(bad_argument_o)))
    else $error("waiting word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind chebyshev_series_evaluator cse_checker u_cse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .result_value_o (result_value_o),
  .bad_argument_o (bad_argument_o),
  .cfg_ready_o    (cfg_ready_o)
);
